@@ hdl/uniform_lbp_3x3_stream_core_defines.svh @@
// ----------------------------------------------------------------------------
// Uniform LBP 3x3 stream core - assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef UNIFORM_LBP_3X3_STREAM_CORE_DEFINES_SVH
`define UNIFORM_LBP_3X3_STREAM_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ULBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ULBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ulbp_pkg.sv @@
// ----------------------------------------------------------------------------
// ulbp_pkg
// Types, sizes and the uniform-pattern lookup for the LBP stream core.
// ----------------------------------------------------------------------------
package ulbp_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int PIX_W       = 8;
  localparam int COORD_W     = 8;
  localparam int SIZE_W      = 9;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int CODE_W      = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int RES_KINDS   = 4;

  localparam logic [SIZE_W-1:0] MIN_SIZE     = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] MAX_W_SIZE   = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_H_SIZE   = SIZE_W'(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(64);
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(64);

  // configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // result kinds, one bit each, emitted lowest bit first:
  // bit0 upper row left, bit1 upper row right edge,
  // bit2 bottom row left, bit3 bottom row right edge
  typedef logic [RES_KINDS-1:0] res_mask_t;

  // one classified pixel passed from front to back
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    res_mask_t          mask;
    logic               row_zero;
    logic               first_col;
    logic               done;
  } q_item_t;

  typedef logic [CODE_W-1:0] uni_lut_t [256];

  function automatic logic is_uniform8(logic [7:0] v);
    logic [7:0] diff;
    int         cnt;
    diff = v ^ {v[0], v[7:1]};
    cnt  = 0;
    for (int i = 0; i < 8; i++) begin
      cnt += int'(diff[i]);
    end
    return cnt <= 2;
  endfunction

  function automatic uni_lut_t build_uni_lut();
    uni_lut_t lut;
    int       idx;
    idx = 1;
    for (int k = 0; k < 256; k++) begin
      if (is_uniform8(8'(k))) begin
        lut[k] = CODE_W'(idx);
        idx++;
      end else begin
        lut[k] = '0;
      end
    end
    return lut;
  endfunction

  localparam uni_lut_t UNI_LUT = build_uni_lut();

endpackage

@@ hdl/ulbp_queue.sv @@
// ----------------------------------------------------------------------------
// ulbp_queue
// Small register FIFO between the classifier and the window back end.
// ----------------------------------------------------------------------------
module ulbp_queue
  import ulbp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  input  q_item_t push_item_i,
  output logic    pop_valid_o,
  input  logic    pop_ready_i,
  output q_item_t pop_item_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t           slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ hdl/ulbp_front.sv @@
// ----------------------------------------------------------------------------
// ulbp_front
// Frame size registers, raster counters and per-pixel result classification.
// ----------------------------------------------------------------------------
module ulbp_front
  import ulbp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [SIZE_W-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PIX_W-1:0]   pixel_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output q_item_t            push_item_o
);

  logic [SIZE_W-1:0]  width_q, width_d, height_q, height_d;
  logic [SIZE_W-1:0]  cfg_clamped;
  logic [COORD_W-1:0] row_q, row_d, col_q, col_d;
  logic [COORD_W-1:0] r0, c0, r, c;
  logic [SIZE_W-1:0]  r_inc;
  logic               row_wrap, col_wrap, last_col, last_row, accept;

  // out-of-range sizes saturate at write time
  always_comb begin
    if (cfg_wdata_i < MIN_SIZE) begin
      cfg_clamped = MIN_SIZE;
    end else if (cfg_wdata_i > MAX_W_SIZE) begin
      cfg_clamped = MAX_W_SIZE;
    end else begin
      cfg_clamped = cfg_wdata_i;
    end
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  width_d = cfg_clamped;
        CFG_FRAME_HEIGHT: height_d = (cfg_clamped > MAX_H_SIZE) ? MAX_H_SIZE : cfg_clamped;
        default:          width_d = width_q;
      endcase
    end
  end

  // position of this pixel; counters beyond a shrunk frame wrap first
  always_comb begin
    row_wrap = ({1'b0, row_q} >= height_q);
    r0       = row_wrap ? '0 : row_q;
    c0       = row_wrap ? '0 : col_q;
    col_wrap = ({1'b0, c0} >= width_q);
    r_inc    = {1'b0, r0} + SIZE_W'(1);
    if (col_wrap) begin
      r = (r_inc >= height_q) ? '0 : r_inc[COORD_W-1:0];
      c = '0;
    end else begin
      r = r0;
      c = c0;
    end
    last_col = ({1'b0, c} == width_q - SIZE_W'(1));
    last_row = ({1'b0, r} == height_q - SIZE_W'(1));
  end

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i & push_ready_i;

  always_comb begin
    push_item_o.pixel     = pixel_i;
    push_item_o.row       = r;
    push_item_o.col       = c;
    push_item_o.row_zero  = (r == '0);
    push_item_o.first_col = (c == '0);
    push_item_o.done      = last_col & last_row;
    push_item_o.mask[0]   = (r != '0) & (c != '0);
    push_item_o.mask[1]   = (r != '0) & last_col;
    push_item_o.mask[2]   = (r != '0) & last_row & (c != '0);
    push_item_o.mask[3]   = (r != '0) & last_row & last_col;
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      col_d = last_col ? '0 : c + COORD_W'(1);
      if (last_col) begin
        row_d = last_row ? '0 : r + COORD_W'(1);
      end else begin
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
      row_q    <= '0;
      col_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      row_q    <= row_d;
      col_q    <= col_d;
    end
  end

endmodule

@@ hdl/ulbp_back.sv @@
// ----------------------------------------------------------------------------
// ulbp_back
// Line stores, 3x3 window and result emission, one result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module ulbp_back
  import ulbp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  q_item_t            pop_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CODE_W-1:0]  uniform_code_o,
  output logic [PIX_W-1:0]   raw_pattern_o,
  output logic [COORD_W-1:0] out_row_o,
  output logic [COORD_W-1:0] out_col_o,
  output logic               frame_done_o,
  output logic               last_o
);

  // line stores
  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
  logic [PIX_W-1:0] older_rd_q, newer_rd_q;

  // fetch stage
  q_item_t s1_item_q;
  logic    s1_valid_q, s1_valid_d;

  // window stage
  logic [PIX_W-1:0]   win_q [3][3];
  logic [PIX_W-1:0]   new_col [3];
  logic               s2_valid_q, s2_valid_d;
  res_mask_t          mask_q, mask_d;
  logic [COORD_W-1:0] s2_row_q, s2_col_q;
  logic               s2_done_q;

  // output register
  logic               out_valid_q;
  logic [CODE_W-1:0]  code_q;
  logic [PIX_W-1:0]   pat_q;
  logic [COORD_W-1:0] orow_q, ocol_q;
  logic               fdone_q, last_q;

  logic               out_load, emit, finish, s2_free, xfer, fetch;
  res_mask_t          lowbit, mask_rem;
  logic               low_rows, end_cols;
  logic [1:0]         rsel [3];
  logic [1:0]         csel [3];
  logic [PIX_W-1:0]   view [3][3];
  logic [PIX_W-1:0]   pattern;
  logic [COORD_W-1:0] res_row, res_col;

  assign out_load = !out_valid_q || out_ready_i;
  assign lowbit   = mask_q & (~mask_q + res_mask_t'(1));
  assign mask_rem = mask_q & ~lowbit;
  assign emit     = s2_valid_q && (mask_q != '0) && out_load;
  assign finish   = s2_valid_q && ((mask_q == '0) || (emit && (mask_rem == '0)));
  assign s2_free  = !s2_valid_q || finish;
  assign xfer     = s1_valid_q && s2_free;
  assign fetch    = pop_valid_i && (!s1_valid_q || xfer);
  assign pop_ready_o = !s1_valid_q || xfer;

  // read at fetch, write when the pixel moves into the window
  always_ff @(posedge clk_i) begin
    if (fetch) begin
      older_rd_q <= older_mem[pop_item_i.col];
      newer_rd_q <= newer_mem[pop_item_i.col];
    end
    if (xfer) begin
      older_mem[s1_item_q.col] <= s1_item_q.row_zero ? s1_item_q.pixel : newer_rd_q;
      newer_mem[s1_item_q.col] <= s1_item_q.pixel;
    end
  end

  always_comb begin
    new_col[0] = s1_item_q.row_zero ? s1_item_q.pixel : older_rd_q;
    new_col[1] = s1_item_q.row_zero ? s1_item_q.pixel : newer_rd_q;
    new_col[2] = s1_item_q.pixel;
  end

  // neighborhood view for the kind being emitted: bottom-row results
  // repeat the last row, right-edge results repeat the last column
  always_comb begin
    low_rows = lowbit[2] | lowbit[3];
    end_cols = lowbit[1] | lowbit[3];
    for (int i = 0; i < 3; i++) begin
      rsel[i] = (i == 2) ? 2'd2 : 2'(i) + 2'(low_rows);
      csel[i] = (i == 2) ? 2'd2 : 2'(i) + 2'(end_cols);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        view[i][j] = win_q[rsel[i]][csel[j]];
      end
    end
    pattern[0] = view[2][2] >= view[1][1];
    pattern[1] = view[2][1] >= view[1][1];
    pattern[2] = view[2][0] >= view[1][1];
    pattern[3] = view[1][2] >= view[1][1];
    pattern[4] = view[1][0] >= view[1][1];
    pattern[5] = view[0][2] >= view[1][1];
    pattern[6] = view[0][1] >= view[1][1];
    pattern[7] = view[0][0] >= view[1][1];
    res_row = low_rows ? s2_row_q : s2_row_q - COORD_W'(1);
    res_col = end_cols ? s2_col_q : s2_col_q - COORD_W'(1);
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (fetch) begin
      s1_valid_d = 1'b1;
    end else if (xfer) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    mask_d     = mask_q;
    if (xfer) begin
      s2_valid_d = 1'b1;
      mask_d     = s1_item_q.mask;
    end else if (finish) begin
      s2_valid_d = 1'b0;
      mask_d     = '0;
    end else if (emit) begin
      mask_d = mask_rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      mask_q     <= mask_d;
      if (out_load) begin
        out_valid_q <= emit;
      end
      if (xfer) begin
        for (int k = 0; k < 3; k++) begin
          if (s1_item_q.first_col) begin
            win_q[k][0] <= new_col[k];
            win_q[k][1] <= new_col[k];
          end else begin
            win_q[k][0] <= win_q[k][1];
            win_q[k][1] <= win_q[k][2];
          end
          win_q[k][2] <= new_col[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch) begin
      s1_item_q <= pop_item_i;
    end
    if (xfer) begin
      s2_row_q  <= s1_item_q.row;
      s2_col_q  <= s1_item_q.col;
      s2_done_q <= s1_item_q.done;
    end
    if (emit) begin
      code_q  <= UNI_LUT[pattern];
      pat_q   <= pattern;
      orow_q  <= res_row;
      ocol_q  <= res_col;
      last_q  <= (mask_rem == '0);
      fdone_q <= (mask_rem == '0) && s2_done_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign uniform_code_o = code_q;
  assign raw_pattern_o  = pat_q;
  assign out_row_o      = orow_q;
  assign out_col_o      = ocol_q;
  assign frame_done_o   = fdone_q;
  assign last_o         = last_q;

endmodule

@@ hdl/uniform_lbp_3x3_stream_core.sv @@
// ----------------------------------------------------------------------------
// uniform_lbp_3x3_stream_core
// Streaming 3x3 uniform local binary pattern with clamped borders.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one per transaction. For each pixel the core
// produces the 8-bit neighbor comparison pattern (bit set when the neighbor
// is >= the center) and its uniform index (1..58, 0 for non-uniform), tagged
// with row and column. Results trail the input by one row and one pixel: row 0
// gives no results, and the pixels of the last row are reported together with
// the row above, so a last-row pixel past column 0 yields two results (up to
// four at the right edge). Sustained rate: one pixel per cycle on all rows but
// the last while the output does not stall; there the single result emitter
// (one result per cycle into the output register) sets the pace. A pixel's
// first result passes the queue, fetch, window and output registers in turn.
// The line stores need no clearing after reset; row 0 fills them before they
// are read. Frame size is to be written through the config port only while
// the core is idle (the core does not enforce this); sizes saturate to 2..256.
// ----------------------------------------------------------------------------
module uniform_lbp_3x3_stream_core
  import ulbp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write port: index 0 frame_width, index 1 frame_height
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [SIZE_W-1:0]  cfg_wdata_i,
  // pixel input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PIX_W-1:0]   pixel_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CODE_W-1:0]  uniform_code_o,
  output logic [PIX_W-1:0]   raw_pattern_o,
  output logic [COORD_W-1:0] out_row_o,
  output logic [COORD_W-1:0] out_col_o,
  output logic               frame_done_o,
  output logic               last_o
);

  // front -> queue
  logic    push_valid, push_ready;
  q_item_t push_item;
  // queue -> back
  logic    pop_valid, pop_ready;
  q_item_t pop_item;

  // Front: holds frame size and raster counters, tags each pixel with its
  // position and the set of results it triggers.
  ulbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_i      (pixel_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // Decoupling queue: input keeps flowing until its two entries fill while the
  // back end spends extra cycles on last-row pixels or waits on the output.
  ulbp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Back: line store read, window shift, pattern + LUT, output register.
  ulbp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_item_i     (pop_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .uniform_code_o (uniform_code_o),
    .raw_pattern_o  (raw_pattern_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .frame_done_o   (frame_done_o),
    .last_o         (last_o)
  );

endmodule

@@ hdl/ulbp_checker.sv @@
// ----------------------------------------------------------------------------
// ulbp_checker
// Port-level checks for the LBP stream core, bound to the top level.
// ----------------------------------------------------------------------------
`include "uniform_lbp_3x3_stream_core_defines.svh"

module ulbp_checker
  import ulbp_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic               cfg_idx_i,
  input logic [SIZE_W-1:0]  cfg_wdata_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [PIX_W-1:0]   pixel_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [CODE_W-1:0]  uniform_code_o,
  input logic [PIX_W-1:0]   raw_pattern_o,
  input logic [COORD_W-1:0] out_row_o,
  input logic [COORD_W-1:0] out_col_o,
  input logic               frame_done_o,
  input logic               last_o
);

  // stalled result holds
  `ULBP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(raw_pattern_o) && $stable(out_row_o) && $stable(out_col_o),
    "stalled result changed")

  // end of frame is always the end of a pixel's results
  `ULBP_ASSERT_NOW(a_done_last, clk_i, rst_ni, out_valid_o && frame_done_o, last_o,
    "frame_done without last")

  // all neighbors at or above the center map to the top uniform index
  `ULBP_ASSERT_NOW(a_flat_code, clk_i, rst_ni, out_valid_o && (raw_pattern_o == 8'hFF),
    uniform_code_o == 6'd58, "all-ones pattern not mapped to 58")

  // remaining results of one pixel follow without a gap
  `ULBP_ASSERT_NEXT(a_burst, clk_i, rst_ni, out_valid_o && out_ready_i && !last_o,
    out_valid_o, "gap inside a pixel's results")

endmodule

bind uniform_lbp_3x3_stream_core ulbp_checker u_checker (.*);

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the uniform LBP 3x3 stream core.
// ----------------------------------------------------------------------------
// Pixels go in through the valid/ready input channel. Each accepted
// transaction is run through a behavioral predictor of the core: line stores,
// the 3x3 window, border clamping, the uniform index and the
// row/column/frame bookkeeping. The expected results are queued. Every result
// transaction is compared with the oldest queued expectation.
//
// Stimulus is made of four parts:
//   - a short run at the reset frame size,
//   - a table of directed frames, some with typed expected patterns,
//   - random phases with small frames, out-of-range sizes and frames
//     that are cut short and then resized,
//   - an oversized frame cut short, then narrowed to the 2x2 minimum.
// Both channels stall at random. Some phases run with no stalls at all.
// ----------------------------------------------------------------------------
module testbench;
  import ulbp_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 12;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int RANDOM_ITEMS   = 200;
  localparam int OVERSIZE_ITEMS = 40;
  localparam int SHOWN_ERRORS   = 10;
  localparam int DIRECTED_STEPS = 24;

  // one result transaction, in port order
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [PIX_W-1:0]   pattern;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               done;
    logic               last;
  } lbp_result_t;

  typedef enum logic {STEP_SIZE, STEP_PIXEL} step_kind_t;

  // A directed row either resizes the frame or sends one pixel. When typed
  // is set, the first result caused by the pixel must carry the given
  // pattern and code. The rest of that result comes from the predictor.
  typedef struct packed {
    step_kind_t        kind;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [PIX_W-1:0]  pixel;
    logic              typed;
    logic [PIX_W-1:0]  pattern;
    logic [CODE_W-1:0] code;
  } directed_step_t;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic               cfg_idx   = CFG_FRAME_WIDTH;
  logic [SIZE_W-1:0]  cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [PIX_W-1:0]   pixel     = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CODE_W-1:0]  uniform_code;
  logic [PIX_W-1:0]   raw_pattern;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               frame_done;
  logic               last;

  uniform_lbp_3x3_stream_core DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .pixel_i        (pixel),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .uniform_code_o (uniform_code),
    .raw_pattern_o  (raw_pattern),
    .out_row_o      (out_row),
    .out_col_o      (out_col),
    .frame_done_o   (frame_done),
    .last_o         (last)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: own copy of the line stores, window, position and sizes
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0]  upper_line [MAX_WIDTH];  // row two above the incoming one
  logic [PIX_W-1:0]  lower_line [MAX_WIDTH];  // row just above the incoming one
  logic [PIX_W-1:0]  win [3][3];              // [top/mid/bottom][left/center/right]
  int unsigned       row_pos = 0;
  int unsigned       col_pos = 0;
  logic [SIZE_W-1:0] width_reg  = RESET_WIDTH;
  logic [SIZE_W-1:0] height_reg = RESET_HEIGHT;
  logic [CODE_W-1:0] uniform_rank [256];

  lbp_result_t       expected_results [$];
  int                error_count = 0;
  bit                calm        = 1'b0;      // phase without stalls on either side
  int                ready_hold  = 0;

  // Directed frames. The flat 2x2 frame gives all-ones patterns. In the 3x3
  // frame a bright center above a dark ring gives the all-zero pattern. In
  // the last 3x3 frame, alternating neighbors give a non-uniform pattern.
  directed_step_t directed_steps [DIRECTED_STEPS] = '{
    '{STEP_SIZE,  9'd2, 9'd2, 8'd0,   1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd255, 1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd255, 1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd255, 1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd255, 1'b1, 8'hFF, 6'd58},
    '{STEP_SIZE,  9'd3, 9'd3, 8'd0,   1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd0,   1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd0,   1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd0,   1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd0,   1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd255, 1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd0,   1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd0,   1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd0,   1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd0,   1'b1, 8'h00, 6'd1},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd0,   1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd200, 1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd0,   1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd200, 1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd100, 1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd0,   1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd200, 1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd0,   1'b0, 8'h00, 6'd0},
    '{STEP_PIXEL, 9'd0, 9'd0, 8'd200, 1'b1, 8'h55, 6'd0}
  };

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  // transitions between circularly adjacent bits of a pattern
  function automatic int ring_changes(logic [7:0] p);
    int n;
    n = 0;
    for (int i = 0; i < 8; i++) begin
      if (p[i] != p[(i + 1) % 8]) n++;
    end
    return n;
  endfunction

  // Neighbor comparison on the current window. For the bottom row, the window
  // is read one row lower, with the bottom row clamped. For the right edge,
  // it is read one column further right, with the right column clamped.
  function automatic lbp_result_t lbp_result(bit bottom, bit right_edge,
                                             int unsigned r, int unsigned c);
    int          t, m, l, cc;
    logic [7:0]  ctr;
    lbp_result_t res;
    t   = bottom ? 1 : 0;
    m   = bottom ? 2 : 1;
    l   = right_edge ? 1 : 0;
    cc  = right_edge ? 2 : 1;
    ctr = win[m][cc];
    res.pattern = {win[t][l] >= ctr, win[t][cc] >= ctr, win[t][2] >= ctr,
                   win[m][l] >= ctr, win[m][2] >= ctr,
                   win[2][l] >= ctr, win[2][cc] >= ctr, win[2][2] >= ctr};
    res.code = uniform_rank[res.pattern];
    res.row  = COORD_W'(r);
    res.col  = COORD_W'(c);
    res.done = 1'b0;
    res.last = 1'b0;
    return res;
  endfunction

  // Position past the end of a shrunken frame: the column wraps to the next
  // row, and a row past the end starts a new frame.
  task automatic normalize_position();
    int unsigned w, h;
    w = eff_size(width_reg, MAX_WIDTH);
    h = eff_size(height_reg, MAX_HEIGHT);
    if (row_pos >= h) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic predict_pixel(input logic [PIX_W-1:0] p, input bit typed,
                               input logic [PIX_W-1:0] t_pat,
                               input logic [CODE_W-1:0] t_code);
    int unsigned      w, h, r, c;
    int               n;
    bit               wrapped;
    logic [PIX_W-1:0] col_pix [3];
    lbp_result_t      found [4];
    w = eff_size(width_reg, MAX_WIDTH);
    h = eff_size(height_reg, MAX_HEIGHT);
    normalize_position();
    r = row_pos;
    c = col_pos;

    // row 0 fills both stores so the row above it reads as itself
    if (r == 0) begin
      col_pix[0] = p;
      col_pix[1] = p;
      upper_line[c] = p;
      lower_line[c] = p;
    end else begin
      col_pix[0] = upper_line[c];
      col_pix[1] = lower_line[c];
      upper_line[c] = col_pix[1];
      lower_line[c] = p;
    end
    col_pix[2] = p;

    // on column 0 the left column is clamped to the new one
    for (int k = 0; k < 3; k++) begin
      if (c == 0) begin
        win[k][0] = col_pix[k];
        win[k][1] = col_pix[k];
      end else begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[k][2] = col_pix[k];
    end

    n = 0;
    if (r >= 1) begin
      if (c >= 1) begin
        found[n] = lbp_result(1'b0, 1'b0, r - 1, c - 1);
        n++;
      end
      if (c == w - 1) begin
        found[n] = lbp_result(1'b0, 1'b1, r - 1, c);
        n++;
      end
      if (r == h - 1) begin
        if (c >= 1) begin
          found[n] = lbp_result(1'b1, 1'b0, r, c - 1);
          n++;
        end
        if (c == w - 1) begin
          found[n] = lbp_result(1'b1, 1'b1, r, c);
          n++;
        end
      end
    end

    wrapped = 1'b0;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos = 0;
        wrapped = 1'b1;
      end
    end

    if (n > 0) begin
      found[n - 1].last = 1'b1;
      found[n - 1].done = wrapped;
      if (typed) begin
        found[0].pattern = t_pat;
        found[0].code    = t_code;
      end
    end
    for (int i = 0; i < n; i++) expected_results.push_back(found[i]);
  endtask

  // --------------------------------------------------------------------------
  // Stall lengths: mostly none or short, a few long
  // --------------------------------------------------------------------------
  function automatic int pause_len();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // styles: 0/3 full range, 1 near-flat (many ties), 2 black and white only
  function automatic logic [PIX_W-1:0] next_pixel(int style);
    case (style)
      1:       return PIX_W'(100 + $urandom_range(0, 2));
      2:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly small sizes, now and then below the minimum
  function automatic logic [SIZE_W-1:0] pick_size();
    if ($urandom_range(0, 9) == 0) return SIZE_W'($urandom_range(0, 1));
    return SIZE_W'($urandom_range(2, 9));
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Valid stays up with the same pixel until the transaction is accepted.
  // It is lowered only when a gap follows or when the bench settles.
  task automatic send_pixel(input logic [PIX_W-1:0] p, input bit typed,
                            input logic [PIX_W-1:0] t_pat,
                            input logic [CODE_W-1:0] t_code);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= p;
    do @(posedge clk); while (!in_ready);
    predict_pixel(p, typed, t_pat, t_code);
  endtask

  task automatic send_to_frame_end(input int style, output int n);
    n = 0;
    do begin
      send_pixel(next_pixel(style), 1'b0, '0, '0);
      n++;
    end while (!(row_pos == 0 && col_pos == 0));
  endtask

  // Wait for every expected result. Then allow for an item that is still in
  // flight but causes no result.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(input bit do_w, input bit do_h,
                           input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    if (do_w) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_FRAME_WIDTH;
      cfg_wdata <= w;
      @(posedge clk);
      width_reg = w;
    end
    if (do_h) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_FRAME_HEIGHT;
      cfg_wdata <= h;
      @(posedge clk);
      height_reg = h;
    end
    cfg_we <= 1'b0;
    normalize_position();
  endtask

  // --------------------------------------------------------------------------
  // Result checker and output stalls
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    lbp_result_t got;
    lbp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {uniform_code, raw_pattern, out_row, out_col, frame_done, last};
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_ERRORS)
          $display("unexpected result: code %0d pat %h row %0d col %0d done %b last %b",
                   got.code, got.pattern, got.row, got.col, got.done, got.last);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= SHOWN_ERRORS) begin
            $display("result (%0d,%0d) expected: code %0d pat %h row %0d col %0d done %b last %b",
                     want.row, want.col, want.code, want.pattern, want.row, want.col,
                     want.done, want.last);
            $display("result (%0d,%0d) got:      code %0d pat %h row %0d col %0d done %b last %b",
                     want.row, want.col, got.code, got.pattern, got.row, got.col,
                     got.done, got.last);
          end
        end
      end
    end
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
      ready_hold = pause_len();
    end
  end

  // hang guard
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int                random_sent;
    int                n;
    int                style;
    int                rank;
    int unsigned       frame_px;
    logic [SIZE_W-1:0] new_w;
    logic [SIZE_W-1:0] new_h;
    logic [1:0]        which;

    rank = 0;
    for (int k = 0; k < 256; k++) begin
      if (ring_changes(8'(k)) <= 2) begin
        rank++;
        uniform_rank[k] = CODE_W'(rank);
      end else begin
        uniform_rank[k] = '0;
      end
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Two full rows at the reset size of 64x64 produce the first result row.
    // The frame is left open and then shrunk by the first directed resize.
    random_sent = 0;
    style       = $urandom_range(0, 3);
    repeat (2 * 64) begin
      send_pixel(next_pixel(style), 1'b0, '0, '0);
      random_sent++;
    end

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_SIZE) begin
        settle();
        set_frame(1'b1, 1'b1, directed_steps[i].width, directed_steps[i].height);
      end else begin
        send_pixel(directed_steps[i].pixel, directed_steps[i].typed,
                   directed_steps[i].pattern, directed_steps[i].code);
      end
    end

    // Random phases. A phase that ends mid-frame may only narrow the frame,
    // so that every line store entry read was written in the current frame.
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      calm  = ($urandom_range(0, 4) == 0);
      style = $urandom_range(0, 3);
      which = 2'($urandom_range(1, 3));
      new_h = pick_size();
      if (row_pos == 0 && col_pos == 0)
        new_w = pick_size();
      else
        new_w = SIZE_W'($urandom_range(2, eff_size(width_reg, MAX_WIDTH)));
      set_frame(which[0], which[1], new_w, new_h);
      frame_px = eff_size(width_reg, MAX_WIDTH) * eff_size(height_reg, MAX_HEIGHT);
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, frame_px - 1);
        repeat (n) send_pixel(next_pixel(style), 1'b0, '0, '0);
      end else begin
        send_to_frame_end(style, n);
      end
      random_sent += n;
    end

    // oversized sizes saturate to 256x256; only part of row 0 is sent
    settle();
    calm  = 1'b0;
    style = $urandom_range(0, 3);
    set_frame(1'b1, 1'b1, 9'h1FF, 9'd300);
    repeat (OVERSIZE_ITEMS) send_pixel(next_pixel(style), 1'b0, '0, '0);

    // zero and one both saturate up to the 2x2 minimum; the open row wraps
    settle();
    set_frame(1'b1, 1'b1, 9'd0, 9'd1);
    send_to_frame_end(style, n);

    settle();
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
